### rtl/csiu_pkg.sv
// Shared types and constants for the CSI raw packed pixel unpacker.
// Used by csiu_unpack and the top level csi_raw_packed_pixel_unpacker_core.
package csiu_pkg;

  // Pixel packing formats
  localparam logic [1:0] FMT_RAW8  = 2'd0;
  localparam logic [1:0] FMT_RAW10 = 2'd1;
  localparam logic [1:0] FMT_RAW12 = 2'd2;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_PACK_FMT    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_START_SKIP  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LINE_STRIDE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LINE_PIXELS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LINE_COUNT  = 3'd4;

  // Register reset values
  localparam logic [1:0]  RST_PACK_FMT    = FMT_RAW10;
  localparam logic [15:0] RST_START_SKIP  = 16'd0;
  localparam logic [15:0] RST_LINE_STRIDE = 16'd1280;
  localparam logic [13:0] RST_LINE_PIXELS = 14'd1024;
  localparam logic [13:0] RST_LINE_COUNT  = 14'd768;

  // Default width of the row and column counters
  localparam int DIM_BITS_DEF = 14;

  // Max pixels produced by one byte
  localparam int MAX_PIX = 4;

  typedef struct packed {
    logic [1:0]  pack_fmt;
    logic [15:0] start_skip;
    logic [15:0] line_stride;
    logic [13:0] line_pixels;
    logic [13:0] line_count;
  } cfg_t;

  typedef struct packed {
    logic [15:0] value;
    logic [13:0] column;
    logic [13:0] row;
    logic        line_end;
    logic        frame_end;
  } pix_t;

endpackage

### rtl/csiu_unpack.sv
// Frame, line and group counters plus the RAW8/10/12 byte unpacking.
// Depends on csiu_pkg for cfg_t and pix_t.
module csiu_unpack import csiu_pkg::*; #(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             go,        // consume the held byte this cycle
  input  logic [7:0]       data_byte,
  input  logic             frame_start,
  output logic [2:0]       pix_cnt,   // pixels this byte yields
  output pix_t [MAX_PIX-1:0] pix
);

  // compare width wide enough for counters plus a small offset and 14-bit config
  localparam int CW = (DIM_BITS + 2 > 15) ? DIM_BITS + 2 : 15;

  logic [15:0]         skip_r, skip_nxt;
  logic [15:0]         bil_r, bil_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt;
  logic [DIM_BITS-1:0] col_r, col_nxt;
  logic [2:0]          big_r, big_nxt;
  logic                done_r, done_nxt;
  logic [7:0]          held_r [MAX_PIX];

  // state after the frame start restart
  logic [15:0]         skip_a, bil_a, bil_inc;
  logic [DIM_BITS-1:0] row_a, col_a, row_inc;
  logic [2:0]          big_a;
  logic                done_a;

  // format shape
  logic [2:0]          gbytes;
  logic                fmt_ok;
  logic [16:0]         line_bytes;
  logic [13:0]         eff_width;
  logic                active;
  logic                hold_we;
  logic [15:0]         pixv [MAX_PIX];
  logic [DIM_BITS-1:0] col_k;

  assign skip_a = frame_start ? cfg.start_skip : skip_r;
  assign bil_a  = frame_start ? '0 : bil_r;
  assign row_a  = frame_start ? '0 : row_r;
  assign col_a  = frame_start ? '0 : col_r;
  assign big_a  = frame_start ? '0 : big_r;
  assign done_a = frame_start ? (cfg.line_count == '0) : done_r;

  assign bil_inc = bil_a + 16'd1;
  assign row_inc = row_a + DIM_BITS'(1);

  // bytes per group, packed line length and pixels per line actually emitted
  always_comb begin
    case (cfg.pack_fmt)
      FMT_RAW8: begin
        gbytes     = 3'd1;
        fmt_ok     = 1'b1;
        line_bytes = 17'(cfg.line_pixels);
        eff_width  = cfg.line_pixels;
      end
      FMT_RAW10: begin
        gbytes     = 3'd5;
        fmt_ok     = 1'b1;
        line_bytes = 17'({cfg.line_pixels[13:2], 2'b00}) + 17'(cfg.line_pixels[13:2]);
        eff_width  = {cfg.line_pixels[13:2], 2'b00};
      end
      FMT_RAW12: begin
        gbytes     = 3'd3;
        fmt_ok     = 1'b1;
        line_bytes = 17'({cfg.line_pixels[13:1], 1'b0}) + 17'(cfg.line_pixels[13:1]);
        eff_width  = {cfg.line_pixels[13:1], 1'b0};
      end
      default: begin
        gbytes     = 3'd1;
        fmt_ok     = 1'b0;
        line_bytes = '0;
        eff_width  = '0;
      end
    endcase
  end

  assign active = fmt_ok && ({1'b0, bil_a} < line_bytes);

  // next state and pixel samples
  always_comb begin
    skip_nxt = skip_a;
    bil_nxt  = bil_a;
    row_nxt  = row_a;
    col_nxt  = col_a;
    big_nxt  = big_a;
    done_nxt = done_a;
    hold_we  = 1'b0;
    pix_cnt  = 3'd0;
    for (int k = 0; k < MAX_PIX; k++) begin
      pixv[k] = '0;
    end
    if (!done_a) begin
      if (skip_a != '0) begin
        skip_nxt = skip_a - 16'd1;
      end else begin
        if (active) begin
          if (cfg.pack_fmt == FMT_RAW8) begin
            pix_cnt = 3'd1;
            pixv[0] = {data_byte, 8'h00};
          end else if ((4'(big_a) + 4'd1) < 4'(gbytes)) begin
            hold_we = 1'b1;
            big_nxt = big_a + 3'd1;
          end else if (cfg.pack_fmt == FMT_RAW10) begin
            // low two bits of each pixel sit in the fifth byte
            pix_cnt = 3'd4;
            pixv[0] = {held_r[0], data_byte[1:0], 6'b0};
            pixv[1] = {held_r[1], data_byte[3:2], 6'b0};
            pixv[2] = {held_r[2], data_byte[5:4], 6'b0};
            pixv[3] = {held_r[3], data_byte[7:6], 6'b0};
            big_nxt = 3'd0;
          end else begin
            // low nibbles sit in the third byte
            pix_cnt = 3'd2;
            pixv[0] = {held_r[0], data_byte[3:0], 4'b0};
            pixv[1] = {held_r[1], data_byte[7:4], 4'b0};
            big_nxt = 3'd0;
          end
        end
        col_nxt = col_a + DIM_BITS'(pix_cnt);
        // line ends by stride, padding included; a zero stride acts as one
        if (bil_inc >= cfg.line_stride || bil_inc == '0) begin
          bil_nxt = '0;
          col_nxt = '0;
          big_nxt = '0;
          row_nxt = row_inc;
          if (CW'(row_inc) >= CW'(cfg.line_count) || row_inc == '0) begin
            done_nxt = 1'b1;
          end
        end else begin
          bil_nxt = bil_inc;
        end
      end
    end
  end

  // per-pixel marks
  always_comb begin
    col_k = '0;
    for (int k = 0; k < MAX_PIX; k++) begin
      col_k           = col_a + DIM_BITS'(k);
      pix[k].value    = pixv[k];
      pix[k].column   = 14'(col_k);
      pix[k].row      = 14'(row_a);
      pix[k].line_end = (CW'(col_a) + CW'(k + 1)) == CW'(eff_width);
      pix[k].frame_end = pix[k].line_end &&
                         ((CW'(row_a) + CW'(1)) == CW'(cfg.line_count));
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= '0;
      bil_r  <= '0;
      row_r  <= '0;
      col_r  <= '0;
      big_r  <= '0;
      done_r <= 1'b1;
    end else if (go) begin
      skip_r <= skip_nxt;
      bil_r  <= bil_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      big_r  <= big_nxt;
      done_r <= done_nxt;
    end
  end

  // held leading bytes of a group
  always_ff @(posedge clk) begin
    if (go && hold_we) begin
      held_r[big_a[1:0]] <= data_byte;
    end
  end

endmodule

### rtl/csi_raw_packed_pixel_unpacker_core.sv
// Top level of the CSI raw packed pixel unpacker: config registers, input
// register and pixel output buffer. Depends on csiu_pkg and csiu_unpack.
//
// in_*   : one received frame byte per request; tdata[7:0] is the byte,
//          tuser[0] marks the first byte of a frame and restarts all counters.
// out_*  : one pixel per request, MSB-aligned 16-bit value with column and
//          row; tuser carries line_end and frame_end, tlast marks the last
//          pixel produced by one input byte.
// cfg_*  : register writes (index on cfg_addr, value on cfg_data), always
//          ready; write only while the block is idle.
// The byte that completes a group is captured in the input register; its pixels
// are then written to the output buffer, from which the first is presented.
// Throughput: one byte per cycle for RAW8, RAW10 and RAW12 while out_tready
// stays high. A RAW10 group yields 4 pixels that leave the output buffer
// while the next group's first bytes are taken in; a byte that yields pixels
// waits in the input register only until the buffer has drained.
// Stalls: when out_tready is low the buffer holds; once the input register
// also holds a pixel-producing byte, in_tready drops.
// Reset: registers return to their defaults and the block ignores bytes
// until the first frame start.
module csi_raw_packed_pixel_unpacker_core import csiu_pkg::*; #(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // byte stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic [0:0]            in_tuser,   // [0] frame_start
  // pixel stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // [15:0] pixel_value, [29:16] pixel_column,
                                            // [43:30] pixel_row, [47:44] zero
  output logic [1:0]            out_tuser,  // [0] line_end, [1] frame_end
  output logic                  out_tlast,  // run_last
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [15:0]           cfg_data
);

  cfg_t cfg_r;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_fs_r;

  pix_t [MAX_PIX-1:0] res;
  logic [2:0]         res_cnt;
  pix_t               slot_r [MAX_PIX];
  logic [2:0]         rem_r;
  logic [1:0]         rd_r;

  logic out_fire, buf_free, go;
  pix_t cur;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pack_fmt    <= RST_PACK_FMT;
      cfg_r.start_skip  <= RST_START_SKIP;
      cfg_r.line_stride <= RST_LINE_STRIDE;
      cfg_r.line_pixels <= RST_LINE_PIXELS;
      cfg_r.line_count  <= RST_LINE_COUNT;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_PACK_FMT:    cfg_r.pack_fmt    <= cfg_data[1:0];
        REG_START_SKIP:  cfg_r.start_skip  <= cfg_data;
        REG_LINE_STRIDE: cfg_r.line_stride <= cfg_data;
        REG_LINE_PIXELS: cfg_r.line_pixels <= cfg_data[13:0];
        REG_LINE_COUNT:  cfg_r.line_count  <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // handshake between input register, unpacker and output buffer
  assign out_fire  = out_tvalid && out_tready;
  assign buf_free  = (rem_r == 3'd0) || (out_fire && rem_r == 3'd1);
  assign go        = in_vld_r && (res_cnt == 3'd0 || buf_free);
  assign in_tready = !in_vld_r || go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_fs_r   <= in_tuser[0];
    end
  end

  csiu_unpack #(
    .DIM_BITS (DIM_BITS)
  ) u_unpack (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .go          (go),
    .data_byte   (in_byte_r),
    .frame_start (in_fs_r),
    .pix_cnt     (res_cnt),
    .pix         (res)
  );

  // output buffer: remaining count and read pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      rd_r  <= '0;
    end else if (go && res_cnt != 3'd0) begin
      rem_r <= res_cnt;
      rd_r  <= '0;
    end else if (out_fire) begin
      rem_r <= rem_r - 3'd1;
      rd_r  <= rd_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_cnt != 3'd0) begin
      for (int k = 0; k < MAX_PIX; k++) begin
        slot_r[k] <= res[k];
      end
    end
  end

  // present the current pixel
  assign cur        = slot_r[rd_r];
  assign out_tvalid = (rem_r != 3'd0);
  assign out_tdata  = {4'b0, cur.row, cur.column, cur.value};
  assign out_tuser  = {cur.frame_end, cur.line_end};
  assign out_tlast  = (rem_r == 3'd1);

endmodule
